### rtl/lbm_pkg.sv
// Shared types, constants and Q3.29 arithmetic helpers for the D2Q9 collision kernel.
// No dependencies; imported by lbm_div, the top level and the testbench.
package lbm_pkg;

  typedef logic signed [31:0] q_t;

  localparam int NPOP = 9;

  // Q3.29 constants
  localparam q_t Q_ONE   = 32'sd536870912;
  localparam q_t W_4_9   = 32'sd238609294;
  localparam q_t W_1_9   = 32'sd59652324;
  localparam q_t W_1_36  = 32'sd14913081;
  localparam logic signed [63:0] Q_ROUND = 64'sd268435456;
  localparam logic signed [39:0] S32_MAX40 = 40'sd2147483647;
  localparam logic signed [39:0] S32_MIN40 = -40'sd2147483648;
  localparam q_t S32_MAX = 32'sh7fffffff;
  localparam q_t S32_MIN = 32'sh80000000;

  localparam logic [30:0] OMEGA_RESET = 31'd1050837209;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_OMEGA = 1'b0;

  // direction tables, in population order
  localparam int DIR_X [NPOP] = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
  localparam int DIR_Y [NPOP] = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
  // weight class per population: 0 = 1/36, 1 = 1/9, 2 = 4/9
  localparam int WCLS [NPOP] = '{0, 1, 0, 1, 2, 1, 0, 1, 0};
  localparam q_t WGT [3] = '{W_1_36, W_1_9, W_4_9};

  // divider geometry
  localparam int NW = 36;            // signed numerator width
  localparam int DW = 33;            // signed divisor width
  localparam int DIV_STEPS = 31;     // quotient bits below the overflow limit
  localparam int DIV_PER_STG = 4;
  localparam int DIV_STG = (DIV_STEPS + DIV_PER_STG - 1) / DIV_PER_STG;
  localparam int DIV_LAT = DIV_STG + 2;
  localparam int PIPE_LAT = 1 + DIV_LAT + 7;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic valid;
    q_t   quo;
  } div_rsp_t;

  function automatic q_t sat32(logic signed [39:0] v);
    if (v > S32_MAX40) return S32_MAX;
    if (v < S32_MIN40) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic q_t add_sat(q_t a, q_t b);
    return sat32(40'(a) + 40'(b));
  endfunction

  function automatic q_t sub_sat(q_t a, q_t b);
    return sat32(40'(a) - 40'(b));
  endfunction

  // Q29 product, rounded half up, saturated
  function automatic q_t qmul(q_t a, q_t b);
    logic signed [63:0] p;
    logic signed [63:0] s;
    p = 64'(a) * 64'(b) + Q_ROUND;
    s = p >>> 29;
    return sat32(s[39:0]);
  endfunction

endpackage

### rtl/lbm_div.sv
// Pipelined signed Q29 divider: trunc(num * 2^29 / den), saturated, zero when flagged.
// Depends on lbm_pkg. Restoring division, DIV_PER_STG quotient bits per stage.
module lbm_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lbm_pkg::div_req_t req_i,
  output lbm_pkg::div_rsp_t rsp_o
);
  import lbm_pkg::*;

  typedef struct packed {
    logic                 valid;
    logic                 zero;
    logic                 ovf;
    logic                 neg;
    logic [1:0]           low;
    logic [DW-1:0]        dm;
    logic [DW-1:0]        rem;
    logic [DIV_STEPS-1:0] quo;
  } stg_t;

  stg_t     st_q [DIV_STG+1];
  stg_t     su;
  div_rsp_t rsp_q;
  logic [NW-1:0] n_mag;
  logic [DW-1:0] d_mag;

  // take magnitudes, flag results at or beyond 4.0
  always_comb begin
    n_mag    = req_i.num[NW-1] ? NW'(-req_i.num) : NW'(req_i.num);
    d_mag    = req_i.den[DW-1] ? DW'(-req_i.den) : DW'(req_i.den);
    su.valid = req_i.valid;
    su.zero  = req_i.zero;
    su.neg   = req_i.num[NW-1] ^ req_i.den[DW-1];
    su.ovf   = (NW+1)'(n_mag) >= (NW+1)'({d_mag, 2'b00});
    su.low   = n_mag[1:0];
    su.dm    = d_mag;
    su.rem   = n_mag[2 +: DW];
    su.quo   = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q[0] <= '0;
    end else begin
      st_q[0] <= su;
    end
  end

  for (genvar g = 1; g <= DIV_STG; g++) begin : g_stg
    stg_t nx;
    always_comb begin
      logic [DW:0] t;
      logic        bi;
      int          s;
      nx = st_q[g-1];
      for (int j = 0; j < DIV_PER_STG; j++) begin
        s = (g - 1) * DIV_PER_STG + j;
        if (s < DIV_STEPS) begin
          bi = (s == 0) ? nx.low[1] : ((s == 1) ? nx.low[0] : 1'b0);
          t  = {nx.rem, bi};
          if (t >= {1'b0, nx.dm}) begin
            nx.rem = DW'(t - {1'b0, nx.dm});
            nx.quo = {nx.quo[DIV_STEPS-2:0], 1'b1};
          end else begin
            nx.rem = t[DW-1:0];
            nx.quo = {nx.quo[DIV_STEPS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_q[g] <= '0;
      end else begin
        st_q[g] <= nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '0;
    end else begin
      rsp_q.valid <= st_q[DIV_STG].valid;
      if (st_q[DIV_STG].zero) begin
        rsp_q.quo <= '0;
      end else if (st_q[DIV_STG].ovf) begin
        rsp_q.quo <= st_q[DIV_STG].neg ? S32_MIN : S32_MAX;
      end else if (st_q[DIV_STG].neg) begin
        rsp_q.quo <= -q_t'({1'b0, st_q[DIV_STG].quo});
      end else begin
        rsp_q.quo <= q_t'({1'b0, st_q[DIV_STG].quo});
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/lattice_boltzmann_d2q9_collide.sv
// D2Q9 BGK collision kernel for one lattice node per clock, APB omega register.
// Depends on lbm_pkg and lbm_div.
//
// One node word enters at every clock edge where start is high; busy stays low, so a
// new node may follow every cycle with no gaps. Each node leaves in the order taken,
// marked by a one-cycle done_o strobe. The result ports hold for that single cycle
// only and the receiver cannot stall, so the consumer must take every result as it
// appears. The pipeline runs through the capture stage, the velocity and inlet-density
// dividers (one setup stage, eight stages of up to four quotient bits, one output
// stage) and seven stages of the equilibrium and relaxation math, each holding one
// rank of 32x32 multipliers or a short saturating add chain. Write omega only while
// no node is in flight; pready is always high, reads give omega if paddr[2] is 0, else 0.
module lattice_boltzmann_d2q9_collide (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  lbm_pkg::q_t                in_pop_0_i,
  input  lbm_pkg::q_t                in_pop_1_i,
  input  lbm_pkg::q_t                in_pop_2_i,
  input  lbm_pkg::q_t                in_pop_3_i,
  input  lbm_pkg::q_t                in_pop_4_i,
  input  lbm_pkg::q_t                in_pop_5_i,
  input  lbm_pkg::q_t                in_pop_6_i,
  input  lbm_pkg::q_t                in_pop_7_i,
  input  lbm_pkg::q_t                in_pop_8_i,
  input  logic                       is_obstacle_i,
  input  logic                       is_inlet_i,
  input  lbm_pkg::q_t                inlet_ux_i,
  // result channel
  output logic                       done_o,
  output lbm_pkg::q_t                out_pop_0_o,
  output lbm_pkg::q_t                out_pop_1_o,
  output lbm_pkg::q_t                out_pop_2_o,
  output lbm_pkg::q_t                out_pop_3_o,
  output lbm_pkg::q_t                out_pop_4_o,
  output lbm_pkg::q_t                out_pop_5_o,
  output lbm_pkg::q_t                out_pop_6_o,
  output lbm_pkg::q_t                out_pop_7_o,
  output lbm_pkg::q_t                out_pop_8_o,
  output lbm_pkg::q_t                density_o,
  output lbm_pkg::q_t                vel_x_o,
  output lbm_pkg::q_t                vel_y_o,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lbm_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import lbm_pkg::*;

  typedef struct packed {
    logic                 valid;
    logic                 obst;
    logic                 inlet;
    q_t                   iux;
    q_t                   rho;
    logic signed [NW-1:0] mx;
    logic signed [NW-1:0] my;
    logic signed [NW-1:0] num;
    logic signed [DW-1:0] den;
    q_t [NPOP-1:0]        f;
  } in_t;

  typedef struct packed {
    logic          valid;
    logic          obst;
    logic          inlet;
    q_t            iux;
    q_t            rho;
    q_t [NPOP-1:0] f;
  } side_t;

  typedef struct packed {
    logic          valid;
    logic          obst;
    logic          inlet;
    q_t            rho;
    q_t            ux;
    q_t            uy;
    q_t [NPOP-1:0] f;
  } node_t;

  logic [30:0] omega_q;
  logic        cfg_wr;

  q_t       in_f [NPOP];
  in_t      s1_d, s1_q;
  side_t    side_q [DIV_LAT];
  div_req_t req_a, req_b;
  div_rsp_t rsp_a, rsp_b;

  node_t a_d, a_q, b_q, c_q, d_q, e_d, e_q, f_q, g_q;
  q_t    cu_d   [NPOP];
  q_t    cu_q   [NPOP];
  q_t    bcu_q  [NPOP];
  q_t    cc_q   [NPOP];
  q_t    uxx_q, uyy_q;
  q_t    rw_q   [3];
  q_t    crw_q  [3];
  q_t    bb_d   [NPOP];
  q_t    bb_q   [NPOP];
  q_t    feq_q  [NPOP];
  q_t    dif_d  [NPOP];
  q_t    dif_q  [NPOP];
  q_t    pm_q   [NPOP];
  q_t    res_d  [NPOP];
  q_t    res_q  [NPOP];
  q_t    usqr;

  // ---------------------------------------------------------------------------
  // configuration: omega, written in the APB access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      omega_q <= OMEGA_RESET;
    end else if (cfg_wr && (paddr[2] == REG_OMEGA)) begin
      omega_q <= pwdata[30:0];
    end
  end

  assign prdata = (paddr[2] == REG_OMEGA) ? {1'b0, omega_q} : '0;

  // ---------------------------------------------------------------------------
  // stage 1: capture the node word, form exact moment sums
  // ---------------------------------------------------------------------------
  assign busy = 1'b0;

  assign in_f[0] = in_pop_0_i;
  assign in_f[1] = in_pop_1_i;
  assign in_f[2] = in_pop_2_i;
  assign in_f[3] = in_pop_3_i;
  assign in_f[4] = in_pop_4_i;
  assign in_f[5] = in_pop_5_i;
  assign in_f[6] = in_pop_6_i;
  assign in_f[7] = in_pop_7_i;
  assign in_f[8] = in_pop_8_i;

  always_comb begin
    logic signed [NW-1:0] sum;
    sum = '0;
    for (int k = 0; k < NPOP; k++) begin
      sum = sum + NW'(in_f[k]);
      s1_d.f[k] = in_f[k];
    end
    s1_d.valid = start && !busy;
    s1_d.obst  = is_obstacle_i;
    s1_d.inlet = is_inlet_i;
    s1_d.iux   = inlet_ux_i;
    s1_d.rho   = sat32(40'(sum));
    s1_d.mx    = NW'(in_f[0]) + NW'(in_f[1]) + NW'(in_f[2])
               - NW'(in_f[6]) - NW'(in_f[7]) - NW'(in_f[8]);
    s1_d.my    = NW'(in_f[0]) + NW'(in_f[3]) + NW'(in_f[6])
               - NW'(in_f[2]) - NW'(in_f[5]) - NW'(in_f[8]);
    s1_d.num   = NW'(in_f[3]) + NW'(in_f[4]) + NW'(in_f[5])
               + ((NW'(in_f[6]) + NW'(in_f[7]) + NW'(in_f[8])) <<< 1);
    s1_d.den   = DW'(Q_ONE) - DW'(inlet_ux_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // dividers: lane A gives ux, or the inlet density; lane B gives uy
  // ---------------------------------------------------------------------------
  always_comb begin
    req_a.valid = s1_q.valid;
    req_b.valid = s1_q.valid;
    if (s1_q.inlet) begin
      req_a.zero = (s1_q.den == '0);
      req_a.num  = s1_q.num;
      req_a.den  = s1_q.den;
    end else begin
      req_a.zero = (s1_q.rho == '0);
      req_a.num  = s1_q.mx;
      req_a.den  = DW'(s1_q.rho);
    end
    req_b.zero = (s1_q.rho == '0);
    req_b.num  = s1_q.my;
    req_b.den  = DW'(s1_q.rho);
  end

  lbm_div u_div_a (.clk_i, .rst_ni, .req_i(req_a), .rsp_o(rsp_a));
  lbm_div u_div_b (.clk_i, .rst_ni, .req_i(req_b), .rsp_o(rsp_b));

  // carry the rest of the node word alongside the dividers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) side_q[i] <= '0;
    end else begin
      side_q[0].valid <= s1_q.valid;
      side_q[0].obst  <= s1_q.obst;
      side_q[0].inlet <= s1_q.inlet;
      side_q[0].iux   <= s1_q.iux;
      side_q[0].rho   <= s1_q.rho;
      side_q[0].f     <= s1_q.f;
      for (int i = 1; i < DIV_LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage A: pick density and velocity, form cu per direction
  // ---------------------------------------------------------------------------
  always_comb begin
    logic signed [39:0] vx, vy;
    q_t                 s;
    a_d.valid = side_q[DIV_LAT-1].valid;
    a_d.obst  = side_q[DIV_LAT-1].obst;
    a_d.inlet = side_q[DIV_LAT-1].inlet;
    a_d.f     = side_q[DIV_LAT-1].f;
    if (side_q[DIV_LAT-1].inlet) begin
      a_d.rho = rsp_a.quo;
      a_d.ux  = side_q[DIV_LAT-1].iux;
      a_d.uy  = '0;
    end else begin
      a_d.rho = side_q[DIV_LAT-1].rho;
      a_d.ux  = rsp_a.quo;
      a_d.uy  = rsp_b.quo;
    end
    for (int k = 0; k < NPOP; k++) begin
      vx = (DIR_X[k] == 1) ? 40'(a_d.ux) : ((DIR_X[k] == -1) ? -40'(a_d.ux) : 40'sd0);
      vy = (DIR_Y[k] == 1) ? 40'(a_d.uy) : ((DIR_Y[k] == -1) ? -40'(a_d.uy) : 40'sd0);
      s  = sat32(vx + vy);
      cu_d[k] = sat32(40'sd3 * 40'(s));
    end
  end

  // ---------------------------------------------------------------------------
  // stage C combinational: usqr and the equilibrium bracket
  // ---------------------------------------------------------------------------
  always_comb begin
    q_t s, half;
    s    = add_sat(uxx_q, uyy_q);
    usqr = sat32((40'sd3 * 40'(s) + 40'sd1) >>> 1);
    for (int k = 0; k < NPOP; k++) begin
      half     = sat32((40'(cc_q[k]) + 40'sd1) >>> 1);
      bb_d[k]  = sub_sat(add_sat(add_sat(Q_ONE, bcu_q[k]), half), usqr);
    end
  end

  // ---------------------------------------------------------------------------
  // stage E combinational: rebuild rightward populations at inlets, deviation
  // ---------------------------------------------------------------------------
  always_comb begin
    e_d = d_q;
    for (int k = 0; k < 3; k++) begin
      if (d_q.inlet) begin
        e_d.f[k] = sub_sat(add_sat(feq_q[k], d_q.f[8-k]), feq_q[8-k]);
      end
    end
    for (int k = 0; k < NPOP; k++) begin
      dif_d[k] = sub_sat(e_d.f[k], feq_q[k]);
    end
  end

  // stage G combinational: relax, or bounce back at solid nodes
  always_comb begin
    for (int k = 0; k < NPOP; k++) begin
      res_d[k] = f_q.obst ? f_q.f[8-k] : sub_sat(f_q.f[k], pm_q[k]);
    end
  end

  // node context through stages A..G
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q <= '0;
      b_q <= '0;
      c_q <= '0;
      d_q <= '0;
      e_q <= '0;
      f_q <= '0;
      g_q <= '0;
    end else begin
      a_q <= a_d;
      b_q <= a_q;
      c_q <= b_q;
      d_q <= c_q;
      e_q <= e_d;
      f_q <= e_q;
      g_q <= f_q;
    end
  end

  // arithmetic payload, no reset
  always_ff @(posedge clk_i) begin
    // stage A
    cu_q  <= cu_d;
    // stage B: squares and weighted density
    for (int k = 0; k < NPOP; k++) begin
      cc_q[k]  <= qmul(cu_q[k], cu_q[k]);
      bcu_q[k] <= cu_q[k];
    end
    uxx_q <= qmul(a_q.ux, a_q.ux);
    uyy_q <= qmul(a_q.uy, a_q.uy);
    for (int i = 0; i < 3; i++) rw_q[i] <= qmul(a_q.rho, WGT[i]);
    // stage C
    bb_q  <= bb_d;
    crw_q <= rw_q;
    // stage D: equilibria
    for (int k = 0; k < NPOP; k++) feq_q[k] <= qmul(crw_q[WCLS[k]], bb_q[k]);
    // stage E
    dif_q <= dif_d;
    // stage F: omega times deviation
    for (int k = 0; k < NPOP; k++) pm_q[k] <= qmul(q_t'({1'b0, omega_q}), dif_q[k]);
    // stage G
    res_q <= res_d;
  end

  // ---------------------------------------------------------------------------
  // result word
  // ---------------------------------------------------------------------------
  assign done_o      = g_q.valid;
  assign out_pop_0_o = res_q[0];
  assign out_pop_1_o = res_q[1];
  assign out_pop_2_o = res_q[2];
  assign out_pop_3_o = res_q[3];
  assign out_pop_4_o = res_q[4];
  assign out_pop_5_o = res_q[5];
  assign out_pop_6_o = res_q[6];
  assign out_pop_7_o = res_q[7];
  assign out_pop_8_o = res_q[8];
  assign density_o   = g_q.rho;
  assign vel_x_o     = g_q.ux;
  assign vel_y_o     = g_q.uy;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, PIPE_LAT))
    else $error("result word without a matching node word");

  a_omega_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_wr && (paddr[2] == REG_OMEGA)) |=> (omega_q == $past(pwdata[30:0])))
    else $error("omega write lost");

  a_inlet_uy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && g_q.inlet) |-> (vel_y_o == '0))
    else $error("inlet node with nonzero y velocity");

  a_zero_rho: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !g_q.inlet && (density_o == '0)) |-> (vel_x_o == '0) && (vel_y_o == '0))
    else $error("zero density with nonzero velocity");

endmodule

### test/tb_lattice_boltzmann_d2q9_collide.sv
// Self-checking testbench for the D2Q9 BGK collision kernel: it drives node words and
// omega writes, predicts every result word in Q3.29 and compares each one field by field.
// Depends on lbm_pkg and lattice_boltzmann_d2q9_collide.

// One node word as driven, and one predicted or observed result word.
typedef struct {
  lbm_pkg::q_t pop [9];
  logic        obst;
  logic        inlet;
  lbm_pkg::q_t ux;
} node_t;

typedef struct {
  lbm_pkg::q_t pop [9];
  lbm_pkg::q_t rho;
  lbm_pkg::q_t vx;
  lbm_pkg::q_t vy;
} moments_t;

// Node-word scoreboard: predict the collision of each accepted node and match results.
class collide_scoreboard;
  moments_t    pending_q [$];
  logic [30:0] omega_m = lbm_pkg::OMEGA_RESET;
  int          errors = 0;

  static function longint clamp(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q29 product, half-up rounding by an arithmetic shift (floor)
  static function longint qprod(longint a, longint b);
    longint p;
    p = a * b + 64'sd268435456;
    return clamp(p >>> 29);
  endfunction

  // Q29 quotient, truncated toward zero
  static function longint qquot(longint n, longint d);
    longint q;
    longint r;
    q = n / d;
    r = n % d;
    if (q >= 4) return 64'sd2147483647;
    if (q <= -4) return -64'sd2147483648;
    return clamp(q * 64'sd536870912 + (r * 64'sd536870912) / d);
  endfunction

  function void predict_node(node_t n);
    longint   f [9];
    longint   feq [9];
    longint   w [9];
    longint   dx [9];
    longint   dy [9];
    longint   sum, mx, my, rho, ux, uy, usqr, cu, b, den, num, om;
    moments_t r;
    w  = '{14913081, 59652324, 14913081, 59652324, 238609294,
           59652324, 14913081, 59652324, 14913081};
    dx = '{1, 1, 1, 0, 0, 0, -1, -1, -1};
    dy = '{1, 0, -1, 1, 0, -1, 1, 0, -1};
    sum = 0; mx = 0; my = 0;
    for (int k = 0; k < 9; k++) begin
      f[k] = longint'(n.pop[k]);
      sum += f[k];
      mx += dx[k] * f[k];
      my += dy[k] * f[k];
    end
    rho = clamp(sum);
    if (rho != 0) begin
      ux = qquot(mx, rho);
      uy = qquot(my, rho);
    end else begin
      ux = 0;
      uy = 0;
    end
    if (n.inlet) begin
      num = (f[3] + f[4] + f[5]) + 2 * (f[6] + f[7] + f[8]);
      ux = longint'(n.ux);
      uy = 0;
      den = 64'sd536870912 - ux;
      rho = (den != 0) ? qquot(num, den) : 0;
    end
    usqr = qprod(64'sd805306368, clamp(qprod(ux, ux) + qprod(uy, uy)));
    for (int k = 0; k < 9; k++) begin
      cu = clamp(3 * clamp(dx[k] * ux + dy[k] * uy));
      b = clamp(64'sd536870912 + cu);
      b = clamp(b + qprod(64'sd268435456, qprod(cu, cu)));
      b = clamp(b - usqr);
      feq[k] = qprod(qprod(rho, w[k]), b);
    end
    // inlet: rebuild the rightward populations from their opposites
    if (n.inlet)
      for (int k = 0; k < 3; k++) f[k] = clamp(clamp(feq[k] + f[8-k]) - feq[8-k]);
    om = longint'({33'd0, omega_m});
    for (int k = 0; k < 9; k++) begin
      if (n.obst) r.pop[k] = lbm_pkg::q_t'(f[8-k]);
      else r.pop[k] = lbm_pkg::q_t'(clamp(f[k] - qprod(om, clamp(f[k] - feq[k]))));
    end
    r.rho = lbm_pkg::q_t'(rho);
    r.vx = lbm_pkg::q_t'(ux);
    r.vy = lbm_pkg::q_t'(uy);
    pending_q.push_back(r);
  endfunction

  function void compare(string name, lbm_pkg::q_t exp_v, lbm_pkg::q_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_result(moments_t got);
    moments_t e;
    if (pending_q.size() == 0) begin
      $error("result word with no node outstanding");
      errors++;
      return;
    end
    e = pending_q.pop_front();
    for (int k = 0; k < 9; k++) compare($sformatf("out_pop_%0d", k), e.pop[k], got.pop[k]);
    compare("density", e.rho, got.rho);
    compare("vel_x", e.vx, got.vx);
    compare("vel_y", e.vy, got.vy);
  endfunction
endclass

module tb_lattice_boltzmann_d2q9_collide;
  import lbm_pkg::*;

  localparam logic [ADDR_W-1:0] ADDR_OMEGA  = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = 3'd4;  // index one: no register there
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  q_t   in_pop [9] = '{default: '0};
  logic is_obstacle = 1'b0;
  logic is_inlet = 1'b0;
  q_t   inlet_ux = '0;
  logic done_o;
  q_t   out_pop [9];
  q_t   density_o, vel_x_o, vel_y_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int   cycles = 0;

  collide_scoreboard sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  lattice_boltzmann_d2q9_collide dut (
    .clk_i, .rst_ni, .start, .busy,
    .in_pop_0_i(in_pop[0]), .in_pop_1_i(in_pop[1]), .in_pop_2_i(in_pop[2]),
    .in_pop_3_i(in_pop[3]), .in_pop_4_i(in_pop[4]), .in_pop_5_i(in_pop[5]),
    .in_pop_6_i(in_pop[6]), .in_pop_7_i(in_pop[7]), .in_pop_8_i(in_pop[8]),
    .is_obstacle_i(is_obstacle), .is_inlet_i(is_inlet), .inlet_ux_i(inlet_ux),
    .done_o,
    .out_pop_0_o(out_pop[0]), .out_pop_1_o(out_pop[1]), .out_pop_2_o(out_pop[2]),
    .out_pop_3_o(out_pop[3]), .out_pop_4_o(out_pop[4]), .out_pop_5_o(out_pop[5]),
    .out_pop_6_o(out_pop[6]), .out_pop_7_o(out_pop[7]), .out_pop_8_o(out_pop[8]),
    .density_o, .vel_x_o, .vel_y_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Take every result word on the edge that ends its strobe cycle.
  always @(posedge clk_i) begin
    moments_t got;
    if (rst_ni && done_o) begin
      for (int k = 0; k < 9; k++) got.pop[k] = out_pop[k];
      got.rho = density_o;
      got.vx = vel_x_o;
      got.vy = vel_y_o;
      sb.check_result(got);
    end
  end

  // Watchdog: drop out with a failure if the run hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic q_t rand_word();
    return q_t'($urandom());
  endfunction

  // Build a plausible node: near-equilibrium populations around a random density.
  function automatic node_t fluid_node(int spread);
    node_t n;
    longint rho;
    q_t w [9];
    w = '{W_1_36, W_1_9, W_1_36, W_1_9, W_4_9, W_1_9, W_1_36, W_1_9, W_1_36};
    rho = longint'($urandom_range(32'h6000_0000, 32'h1000_0000));
    for (int k = 0; k < 9; k++)
      n.pop[k] = q_t'(((rho * w[k]) >>> 29) + $signed($urandom_range(2 * spread, 0)) - spread);
    n.obst = ($urandom_range(9, 0) == 0);
    n.inlet = ($urandom_range(4, 0) == 0);
    n.ux = q_t'($signed($urandom_range(32'h0800_0000, 0)) - 32'sh0400_0000);
    return n;
  endfunction

  function automatic node_t noise_node();
    node_t n;
    for (int k = 0; k < 9; k++) n.pop[k] = rand_word();
    n.obst = 1'($urandom_range(1, 0));
    n.inlet = 1'($urandom_range(1, 0));
    n.ux = ($urandom_range(7, 0) == 0) ? Q_ONE : rand_word();
    return n;
  endfunction

  // Present one node word and hold it until the kernel takes it.
  task automatic send_node(node_t n);
    for (int k = 0; k < 9; k++) in_pop[k] <= n.pop[k];
    is_obstacle <= n.obst;
    is_inlet <= n.inlet;
    inlet_ux <= n.ux;
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    sb.predict_node(n);
  endtask

  task automatic idle_cycles(int count);
    start <= 1'b0;
    repeat (count) @(posedge clk_i);
  endtask

  // Hold off until every result is back, then let the pipeline drain.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 2) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr == ADDR_OMEGA) sb.omega_m = data[30:0];
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_nodes(int count, bit with_gaps);
    node_t n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9, 0) < 2) n = noise_node();
      else n = fluid_node(($urandom_range(1, 0) == 1) ? 32'h0040_0000 : 32'h0000_1000);
      send_node(n);
      if (with_gaps && $urandom_range(5, 0) == 0) idle_cycles($urandom_range(7, 1));
    end
  endtask

  task automatic directed_nodes();
    node_t n;
    // all zero: zero density gives zero velocity
    for (int k = 0; k < 9; k++) n.pop[k] = '0;
    n.obst = 1'b0; n.inlet = 1'b0; n.ux = '0;
    send_node(n);
    // all at the top: density saturates and still divides the momentum
    for (int k = 0; k < 9; k++) n.pop[k] = S32_MAX;
    send_node(n);
    for (int k = 0; k < 9; k++) n.pop[k] = S32_MIN;
    send_node(n);
    // one population at the top or the bottom extreme in turn, the others at one
    for (int j = 0; j < 9; j += 2) begin
      for (int k = 0; k < 9; k++) n.pop[k] = 32'sd1;
      n.pop[j] = (j % 4 == 0) ? S32_MAX : S32_MIN;
      send_node(n);
    end
    // inlet with unit velocity: divisor zero, density zero
    n = fluid_node(32'h100);
    n.obst = 1'b0; n.inlet = 1'b1; n.ux = Q_ONE;
    send_node(n);
    n.ux = '0;
    send_node(n);
    n.ux = S32_MAX;
    send_node(n);
    n.ux = S32_MIN;
    send_node(n);
    // solid node, then solid inlet using the rebuilt populations
    n = fluid_node(32'h10000);
    n.obst = 1'b1; n.inlet = 1'b0;
    send_node(n);
    n.inlet = 1'b1;
    send_node(n);
    // alternating bit patterns to toggle every input bit
    for (int k = 0; k < 9; k++) n.pop[k] = 32'h5555_5555;
    n.obst = 1'b0; n.inlet = 1'b1; n.ux = 32'hAAAA_AAAA;
    send_node(n);
    for (int k = 0; k < 9; k++) n.pop[k] = 32'hAAAA_AAAA;
    n.obst = 1'b1; n.inlet = 1'b0; n.ux = 32'h5555_5555;
    send_node(n);
    for (int i = 0; i < 4; i++) send_node(noise_node());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 1: reset omega, directed corners, then random traffic.
    directed_nodes();
    random_nodes(60, 1);
    drain();  // sender pauses until all results are back
    random_nodes(60, 1);
    drain();

    // Phase 2: omega zero, also poke the unused address (must be ignored).
    apb_write(ADDR_OMEGA, 32'd0);
    apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    directed_nodes();
    random_nodes(110, 1);
    drain();

    // Phase 3: omega at its widest value, bit 31 of the bus set as well.
    apb_write(ADDR_OMEGA, 32'hFFFF_FFFF);
    random_nodes(110, 1);
    drain();

    // Phase 4: omega exactly two.
    apb_write(ADDR_OMEGA, 32'h4000_0000);
    random_nodes(110, 1);
    drain();

    // Phase 5: random omega in the useful range, back to back with no gaps.
    apb_write(ADDR_OMEGA, $urandom_range(32'h4000_0000, 0));
    random_nodes(130, 0);

    drain();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
